### rtl/rmj_pkg.sv
// Package for the radar measurement Jacobian block: bit widths and byte counts.
// No dependencies.
`default_nettype none
package rmj_pkg;
    localparam int WordBits = 32;
    localparam int FracBits = 16;
    localparam int FloorBits = 16;
    localparam int MagBits = WordBits;
    localparam int C1Bits = 2 * MagBits + 1;
    localparam int C2Bits = MagBits + 1;
    localparam int C3Bits = C1Bits + C2Bits;
    localparam int NmBits = 2 * MagBits + 1;
    localparam int RnBits = MagBits + NmBits;
    localparam int NumBits = RnBits + FracBits;
    localparam int QBits = WordBits + 1;
    localparam int InBytes = (4 * WordBits + 7) / 8;
    localparam int OutBytes = (6 * WordBits + 7) / 8;
endpackage
`default_nettype wire

### rtl/rmj_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sign and saturation.
// Depends on rmj_pkg.
`default_nettype none
module rmj_div (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [rmj_pkg::NumBits-1:0]  num,
    input  wire logic [rmj_pkg::C3Bits-1:0]   den,
    input  wire logic                         neg,
    output logic [rmj_pkg::WordBits-1:0]      quot
);
    localparam int W = rmj_pkg::WordBits;
    localparam int NB = rmj_pkg::NumBits;
    localparam int DB = rmj_pkg::C3Bits;

    // numerator shifts out at the top while quotient bits shift in at the bottom
    for (genvar i = 0; i < NB; i++)
    begin : g_st
        logic [NB-1:0] nq_in;
        logic [DB-1:0] d_in;
        logic [DB-1:0] r_in;
        logic          s_in;
        logic [DB:0]   t;
        logic          ge;
        logic [NB-1:0] nq_reg;
        logic          s_reg;
        if (i == 0)
        begin : g_head
            assign nq_in = num;
            assign d_in = den;
            assign r_in = '0;
            assign s_in = neg;
        end
        else
        begin : g_tail
            assign nq_in = g_st[i-1].nq_reg;
            assign d_in = g_st[i-1].g_carry.d_reg;
            assign r_in = g_st[i-1].g_carry.r_reg;
            assign s_in = g_st[i-1].s_reg;
        end
        assign t = {r_in, nq_in[NB-1]};
        assign ge = t >= {1'b0, d_in};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg <= {nq_in[NB-2:0], ge};
                s_reg <= s_in;
            end
        end
        if (i < NB - 1)
        begin : g_carry
            logic [DB-1:0] d_reg;
            logic [DB-1:0] r_reg;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_reg <= d_in;
                    r_reg <= ge ? DB'(t - {1'b0, d_in}) : DB'(t);
                end
            end
        end
    end

    logic [NB-1:0] qf;
    logic          sf;
    logic          big;
    assign qf = g_st[NB-1].nq_reg;
    assign sf = g_st[NB-1].s_reg;
    assign big = qf[NB-1:W-1] != '0;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sf)
                quot <= big ? {1'b1, {(W-1){1'b0}}} : W'(~qf[W-1:0] + 1'b1);
            else
                quot <= big ? {1'b0, {(W-1){1'b1}}} : qf[W-1:0];
        end
    end
endmodule
`default_nettype wire

### rtl/radar_measurement_jacobian.sv
// Top level of the radar measurement Jacobian block.
// Depends on rmj_pkg and rmj_div.
// One state vector per cycle, when not stalled, enters a deep pipeline: magnitudes,
// 64-bit products, c1 and the cross term, a square root settling one result bit per stage
// (33 stages), two stages that build c3 and the rate numerators from split products, then
// six restoring dividers settling one quotient bit per stage (113 stages) with saturation.
// Throughput is one transaction per cycle while no stall holds the pipe. The whole pipe
// advances when the output register is empty or being taken, so a stall holds every stage.
// Write the floor only while the pipe is empty.
`default_nettype none
module radar_measurement_jacobian (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, vel_x, vel_y
    input  wire logic [rmj_pkg::InBytes*8-1:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // d_range_dx, d_range_dy, d_bearing_dx, d_bearing_dy, d_rate_dx, d_rate_dy
    output logic [rmj_pkg::OutBytes*8-1:0] m_tdata,
    // near_origin
    output logic              m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [rmj_pkg::FloorBits-1:0] cfg_data
);
    localparam int W = rmj_pkg::WordBits;
    localparam int F = rmj_pkg::FracBits;
    localparam int M = rmj_pkg::MagBits;
    localparam int C1B = rmj_pkg::C1Bits;
    localparam int C2B = rmj_pkg::C2Bits;
    localparam int C3B = rmj_pkg::C3Bits;
    localparam int NMB = rmj_pkg::NmBits;
    localparam int RNB = rmj_pkg::RnBits;
    localparam int NUMB = rmj_pkg::NumBits;
    localparam int SQ = M + 1;
    localparam int PPB = 2 * M + 2;

    logic en;
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;
    assign cfg_ready = 1'b1;

    logic [rmj_pkg::FloorBits-1:0] floor_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            floor_reg <= rmj_pkg::FloorBits'(7);
        else if (cfg_valid)
            floor_reg <= cfg_data;
    end

    // stage 1: magnitudes and signs
    logic [W-1:0] ix, iy, ivx, ivy;
    assign ix = s_tdata[W-1:0];
    assign iy = s_tdata[2*W-1:W];
    assign ivx = s_tdata[3*W-1:2*W];
    assign ivy = s_tdata[4*W-1:3*W];
    logic [M-1:0] mx_reg, my_reg, mvx_reg, mvy_reg;
    logic nx_reg, ny_reg, nvx_reg, nvy_reg, v1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= ix[W-1] ? W'(-ix) : ix;
            my_reg <= iy[W-1] ? W'(-iy) : iy;
            mvx_reg <= ivx[W-1] ? W'(-ivx) : ivx;
            mvy_reg <= ivy[W-1] ? W'(-ivy) : ivy;
            nx_reg <= ix[W-1];
            ny_reg <= iy[W-1];
            nvx_reg <= ivx[W-1];
            nvy_reg <= ivy[W-1];
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    // stage 2: four products
    logic [2*M-1:0] xx_reg, yy_reg, a_reg, b_reg;
    logic [M-1:0] mx2_reg, my2_reg;
    logic nx2_reg, ny2_reg, na2_reg, nb2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= mx_reg * mx_reg;
            yy_reg <= my_reg * my_reg;
            a_reg <= mvx_reg * my_reg;
            b_reg <= mvy_reg * mx_reg;
            mx2_reg <= mx_reg;
            my2_reg <= my_reg;
            nx2_reg <= nx_reg;
            ny2_reg <= ny_reg;
            na2_reg <= nvx_reg != ny_reg;
            nb2_reg <= !(nvy_reg != nx_reg);
        end
    end

    // stage 3: c1, signed difference, floor test
    logic [C1B-1:0] c1_reg;
    logic [NMB-1:0] nm_reg;
    logic nn_reg;
    logic [M-1:0] mx3_reg, my3_reg;
    logic nx3_reg, ny3_reg, near3_reg;
    logic [C1B-1:0] c1_n;
    assign c1_n = C1B'(xx_reg) + C1B'(yy_reg);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg <= c1_n;
            near3_reg <= (c1_n == '0) || (c1_n < (C1B'(floor_reg) << F));
            if (na2_reg == nb2_reg)
            begin
                nm_reg <= NMB'(a_reg) + NMB'(b_reg);
                nn_reg <= na2_reg;
            end
            else if (a_reg >= b_reg)
            begin
                nm_reg <= NMB'(a_reg - b_reg);
                nn_reg <= na2_reg;
            end
            else
            begin
                nm_reg <= NMB'(b_reg - a_reg);
                nn_reg <= nb2_reg;
            end
            mx3_reg <= mx2_reg;
            my3_reg <= my2_reg;
            nx3_reg <= nx2_reg;
            ny3_reg <= ny2_reg;
        end
    end

    // square root, one result bit per stage, data riding alongside
    typedef struct packed {
        logic [M-1:0]   mx;
        logic [M-1:0]   my;
        logic [NMB-1:0] nm;
        logic           nn;
        logic           nx;
        logic           ny;
        logic           near;
    } ride_t;
    for (genvar k = 0; k < SQ; k++)
    begin : g_sq
        localparam int B = SQ - 1 - k;
        ride_t            rd_in;
        logic [C1B-1:0]   sa_in;
        logic [C2B-1:0]   sr_in;
        logic [C2B-1:0]   cand;
        logic [2*C2B-1:0] sqr;
        ride_t            rd_reg;
        logic [C1B-1:0]   sa_reg;
        logic [C2B-1:0]   sr_reg;
        if (k == 0)
        begin : g_head
            assign rd_in = '{mx: mx3_reg, my: my3_reg, nm: nm_reg, nn: nn_reg,
                             nx: nx3_reg, ny: ny3_reg, near: near3_reg};
            assign sa_in = c1_reg;
            assign sr_in = '0;
        end
        else
        begin : g_tail
            assign rd_in = g_sq[k-1].rd_reg;
            assign sa_in = g_sq[k-1].sa_reg;
            assign sr_in = g_sq[k-1].sr_reg;
        end
        assign cand = sr_in | (C2B'(1) << B);
        assign sqr = cand * cand;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rd_reg <= rd_in;
                sa_reg <= sa_in;
                sr_reg <= (sqr <= (2*C2B)'(sa_in)) ? cand : sr_in;
            end
        end
    end

    // split products for c3 and the rate numerators
    ride_t rd_last;
    logic [C1B-1:0] c1_last;
    logic [C2B-1:0] c2_last;
    assign rd_last = g_sq[SQ-1].rd_reg;
    assign c1_last = g_sq[SQ-1].sa_reg;
    assign c2_last = g_sq[SQ-1].sr_reg;

    ride_t rp_reg;
    logic [C1B-1:0] c1p_reg;
    logic [C2B-1:0] c2p_reg;
    logic [PPB-1:0] c3lo_reg, c3hi_reg, ynlo_reg, ynhi_reg, xnlo_reg, xnhi_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp_reg <= rd_last;
            c1p_reg <= c1_last;
            c2p_reg <= c2_last;
            c3lo_reg <= c1_last[M-1:0] * c2_last;
            c3hi_reg <= c1_last[C1B-1:M] * c2_last;
            ynlo_reg <= rd_last.my * rd_last.nm[M-1:0];
            ynhi_reg <= rd_last.my * rd_last.nm[NMB-1:M];
            xnlo_reg <= rd_last.mx * rd_last.nm[M-1:0];
            xnhi_reg <= rd_last.mx * rd_last.nm[NMB-1:M];
        end
    end

    // combine partial products
    ride_t rq_reg;
    logic [C1B-1:0] c1q_reg;
    logic [C2B-1:0] c2q_reg;
    logic [C3B-1:0] c3_reg;
    logic [RNB-1:0] yn_reg, xn_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rq_reg <= rp_reg;
            c1q_reg <= c1p_reg;
            c2q_reg <= c2p_reg;
            c3_reg <= C3B'(c3lo_reg) + (C3B'(c3hi_reg) << M);
            yn_reg <= RNB'(ynlo_reg) + (RNB'(ynhi_reg) << M);
            xn_reg <= RNB'(xnlo_reg) + (RNB'(xnhi_reg) << M);
        end
    end

    logic [W-1:0] q0, q1, q2, q3, q4, q5;
    rmj_div u_d0 (
        .clk, .en, .num(NUMB'({rq_reg.mx, {F{1'b0}}})), .den(C3B'(c2q_reg)),
        .neg(rq_reg.nx), .quot(q0));
    rmj_div u_d1 (
        .clk, .en, .num(NUMB'({rq_reg.my, {F{1'b0}}})), .den(C3B'(c2q_reg)),
        .neg(rq_reg.ny), .quot(q1));
    rmj_div u_d2 (
        .clk, .en, .num(NUMB'({rq_reg.my, {(2*F){1'b0}}})), .den(C3B'(c1q_reg)),
        .neg(!rq_reg.ny), .quot(q2));
    rmj_div u_d3 (
        .clk, .en, .num(NUMB'({rq_reg.mx, {(2*F){1'b0}}})), .den(C3B'(c1q_reg)),
        .neg(rq_reg.nx), .quot(q3));
    rmj_div u_d4 (
        .clk, .en, .num(NUMB'({yn_reg, {F{1'b0}}})), .den(c3_reg),
        .neg(rq_reg.ny != rq_reg.nn), .quot(q4));
    rmj_div u_d5 (
        .clk, .en, .num(NUMB'({xn_reg, {F{1'b0}}})), .den(c3_reg),
        .neg(rq_reg.nx != !rq_reg.nn), .quot(q5));

    // near flag rides beside the dividers
    logic [NUMB:0] np_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            np_reg <= {np_reg[NUMB-1:0], rq_reg.near};
    end

    // valid pipeline: stages 1..3, sqrt, two product stages, divider stages, divider output
    localparam int VL = 2 + SQ + 2 + NUMB + 1;
    logic [VL-1:0] vp_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp_reg <= '0;
        else if (en)
            vp_reg <= {vp_reg[VL-2:0], v1_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (en)
            m_tvalid <= vp_reg[VL-1];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tuser <= np_reg[NUMB];
            m_tdata <= np_reg[NUMB] ? '0 : {q5, q4, q3, q2, q1, q0};
        end
    end
endmodule
`default_nettype wire
